// ===== hdl/ivra_pkg.sv =====
`default_nettype none
package ivra_pkg;

    // Default size of each vector bitmap
    localparam int IVRA_NUM_VECTORS = 256;

    // First vector of the scan for the base level, and the log2 of the block size per level
    localparam int IVRA_SCAN_BASE   = 32;
    localparam int IVRA_BLOCK_SHIFT = 4;

    // Reset value of base_level
    localparam logic [3:0] IVRA_BASE_LEVEL_RESET = 4'd2;

    // Request modes
    localparam logic IVRA_MODE_ALLOC = 1'b0;
    localparam logic IVRA_MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] IVRA_ST_OK       = 2'd0;
    localparam logic [1:0] IVRA_ST_NO_ROOM  = 2'd1;
    localparam logic [1:0] IVRA_ST_LOW_LVL  = 2'd2;
    localparam logic [1:0] IVRA_ST_ZERO_LEN = 2'd3;

    // Request word
    typedef struct packed {
        logic       mode;
        logic [8:0] run_length;
        logic [3:0] priority_level;
        logic       want_shared;
        logic [7:0] first_vector;
    } ivra_req_t;

    // Result word
    typedef struct packed {
        logic [7:0] granted_vector;
        logic [1:0] status;
    } ivra_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/interrupt_vector_run_allocator_top.sv =====
`default_nettype none
// Interrupt vector run allocator. Two bitmaps of NUM_VECTORS bits (exclusive and
// shareable) live in single-port-write, registered-read memories. After reset the
// block clears both maps and takes no request meanwhile; cfg_wr_en writes
// base_level at any time. An allocate scans the maps one vector a cycle from
// 32 + (priority_level - base_level) * 16 with a run counter up to the hit; a
// shared request that finds no run free in both maps makes a second pass against
// the exclusive map alone. A hit is then marked vector by vector. A free clears
// the run vector by vector; rejected requests go straight to the result. The
// scan is bound by the one memory read port per map. One request is in work at
// a time; a finished result waits in the output register.
module interrupt_vector_run_allocator_top
    import ivra_pkg::*;
#(
    parameter int NUM_VECTORS = IVRA_NUM_VECTORS
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire ivra_req_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output ivra_rsp_t       m_data
);

    localparam int IDXW = $clog2(NUM_VECTORS);
    localparam int SW   = (IDXW + 1 > 9) ? IDXW + 1 : 9;
    localparam logic [SW-1:0] NUM_W  = SW'(NUM_VECTORS);
    localparam logic [SW-1:0] LAST_W = SW'(NUM_VECTORS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [3:0]      base_level_reg;
    logic [SW-1:0]   work_addr_reg, work_addr_next;
    logic [SW-1:0]   issue_addr_reg, issue_addr_next;
    logic [SW-1:0]   eval_addr_reg, eval_addr_next;
    logic [SW-1:0]   start_reg, start_next;
    logic [SW-1:0]   cnt_reg, cnt_next;
    logic [SW-1:0]   at_reg, at_next;
    logic [8:0]      len_reg, len_next;
    logic [8:0]      remaining_reg, remaining_next;
    logic            pend_reg, pend_next;
    logic            shared_reg, shared_next;
    logic            both_reg, both_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic [7:0]      res_granted_reg, res_granted_next;
    logic            m_valid_reg, m_valid_next;
    ivra_rsp_t       m_data_reg, m_data_next;

    logic            excl_we, shr_we, wr_bit;
    logic [IDXW-1:0] wr_addr;
    logic            excl_rd, shr_rd;
    logic [SW-1:0]   req_start;
    logic [SW-1:0]   cnt_inc;
    logic            issue_ok;
    logic            bit_free;

    ivra_bitmap_ram #(.DEPTH(NUM_VECTORS), .AW(IDXW)) u_excl_map (
        .aclk    (aclk),
        .wr_en   (excl_we),
        .wr_addr (wr_addr),
        .wr_data (wr_bit),
        .rd_addr (issue_addr_reg[IDXW-1:0]),
        .rd_data (excl_rd)
    );

    ivra_bitmap_ram #(.DEPTH(NUM_VECTORS), .AW(IDXW)) u_shr_map (
        .aclk    (aclk),
        .wr_en   (shr_we),
        .wr_addr (wr_addr),
        .wr_data (wr_bit),
        .rd_addr (issue_addr_reg[IDXW-1:0]),
        .rd_data (shr_rd)
    );

    // Scan start for the requested level
    assign req_start = SW'(IVRA_SCAN_BASE)
                     + (SW'(s_data.priority_level - base_level_reg) << IVRA_BLOCK_SHIFT);

    assign issue_ok = (issue_addr_reg < NUM_W);
    assign bit_free = !excl_rd && (!both_reg || !shr_rd);
    assign cnt_inc  = cnt_reg + SW'(1);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Map write port: clear pass, marking and freeing
    always_comb begin
        wr_addr = work_addr_reg[IDXW-1:0];
        wr_bit  = (state_reg == ST_MARK);
        excl_we = 1'b0;
        shr_we  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                excl_we = 1'b1;
                shr_we  = 1'b1;
            end
            ST_MARK: begin
                excl_we = !shared_reg;
                shr_we  = shared_reg;
            end
            ST_FREE: begin
                excl_we = !shared_reg && (work_addr_reg < NUM_W);
                shr_we  = shared_reg && (work_addr_reg < NUM_W);
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        work_addr_next   = work_addr_reg;
        issue_addr_next  = issue_addr_reg;
        eval_addr_next   = eval_addr_reg;
        start_next       = start_reg;
        cnt_next         = cnt_reg;
        at_next          = at_reg;
        len_next         = len_reg;
        remaining_next   = remaining_reg;
        pend_next        = 1'b0;
        shared_next      = shared_reg;
        both_next        = both_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                // Sweep both maps to zero
                if (work_addr_reg == LAST_W) begin
                    state_next = ST_IDLE;
                end else begin
                    work_addr_next = work_addr_reg + SW'(1);
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    shared_next      = s_data.want_shared;
                    len_next         = s_data.run_length;
                    remaining_next   = s_data.run_length;
                    both_next        = 1'b1;
                    res_granted_next = 8'd0;
                    res_status_next  = IVRA_ST_OK;
                    if (s_data.mode == IVRA_MODE_FREE) begin
                        work_addr_next = SW'(s_data.first_vector);
                        if (s_data.run_length == 9'd0) begin
                            res_status_next = IVRA_ST_ZERO_LEN;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_FREE;
                        end
                    end else if (s_data.priority_level < base_level_reg) begin
                        res_status_next = IVRA_ST_LOW_LVL;
                        state_next      = ST_DONE;
                    end else if (s_data.run_length == 9'd0) begin
                        res_status_next = IVRA_ST_ZERO_LEN;
                        state_next      = ST_DONE;
                    end else if ((req_start >= NUM_W) || (SW'(s_data.run_length) > NUM_W)) begin
                        res_status_next = IVRA_ST_NO_ROOM;
                        state_next      = ST_DONE;
                    end else begin
                        start_next      = req_start;
                        issue_addr_next = req_start;
                        cnt_next        = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Issue one read a cycle, judge the bit that comes back
                if (issue_ok) begin
                    issue_addr_next = issue_addr_reg + SW'(1);
                    eval_addr_next  = issue_addr_reg;
                    pend_next       = 1'b1;
                end
                if (pend_reg) begin
                    if (bit_free) begin
                        cnt_next = cnt_inc;
                    end else begin
                        cnt_next = '0;
                    end
                    if (bit_free && (cnt_inc == SW'(len_reg))) begin
                        at_next        = eval_addr_reg - SW'(len_reg) + SW'(1);
                        work_addr_next = eval_addr_reg - SW'(len_reg) + SW'(1);
                        remaining_next = len_reg;
                        pend_next      = 1'b0;
                        state_next     = ST_MARK;
                    end else if (eval_addr_reg == LAST_W) begin
                        pend_next = 1'b0;
                        if (both_reg && shared_reg) begin
                            // Retry against the exclusive map alone
                            both_next       = 1'b0;
                            issue_addr_next = start_reg;
                            cnt_next        = '0;
                        end else begin
                            res_status_next = IVRA_ST_NO_ROOM;
                            state_next      = ST_DONE;
                        end
                    end
                end
            end

            ST_MARK: begin
                // Set the run one vector a cycle
                if (remaining_reg == 9'd1) begin
                    res_granted_next = at_reg[7:0];
                    state_next       = ST_DONE;
                end else begin
                    work_addr_next = work_addr_reg + SW'(1);
                    remaining_next = remaining_reg - 9'd1;
                end
            end

            ST_FREE: begin
                // Clear the run, drop vectors past the top
                if ((remaining_reg == 9'd1) || (work_addr_reg >= LAST_W)) begin
                    state_next = ST_DONE;
                end else begin
                    work_addr_next = work_addr_reg + SW'(1);
                    remaining_next = remaining_reg - 9'd1;
                end
            end

            ST_DONE: begin
                // Hand the result over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.granted_vector = res_granted_reg;
                    m_data_next.status         = res_status_reg;
                    state_next                 = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            work_addr_reg  <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            base_level_reg <= IVRA_BASE_LEVEL_RESET;
        end else begin
            state_reg     <= state_next;
            work_addr_reg <= work_addr_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                base_level_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        issue_addr_reg  <= issue_addr_next;
        eval_addr_reg   <= eval_addr_next;
        start_reg       <= start_next;
        cnt_reg         <= cnt_next;
        at_reg          <= at_next;
        len_reg         <= len_next;
        remaining_reg   <= remaining_next;
        shared_reg      <= shared_next;
        both_reg        <= both_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        m_data_reg      <= m_data_next;
    end

endmodule
`default_nettype wire

// ===== hdl/ivra_bitmap_ram.sv =====
`default_nettype none
module ivra_bitmap_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_data
);

    logic mem [DEPTH];

    // Write one bit
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ivra_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int NUM_VEC        = IVRA_NUM_VECTORS;
    localparam int PHASE_ITEMS    = 286;
    localparam int SETTLE_CYCLES  = 1000;
    localparam int TIMEOUT_CYCLES = 5_000_000;
    localparam int MAX_SHOWN      = 10;

    // A run that the stimulus believes is held, kept for later frees
    typedef struct {
        int unsigned first_vec;
        int unsigned run_len;
        bit          in_shared;
    } held_run_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [3:0] cfg_wr_data = IVRA_BASE_LEVEL_RESET;
    logic       s_valid     = 1'b0;
    ivra_req_t  s_data      = '0;
    logic       m_ready     = 1'b0;
    logic       s_ready;
    logic       m_valid;
    ivra_rsp_t  m_data;

    // Shadow of the vector maps and the level register
    bit [NUM_VEC-1:0] excl_map = '0;
    bit [NUM_VEC-1:0] shr_map  = '0;
    logic [3:0]       base_level_q = IVRA_BASE_LEVEL_RESET;

    ivra_rsp_t   expected_grants[$];
    held_run_t   held_runs[$];
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    interrupt_vector_run_allocator_top #(
        .NUM_VECTORS (NUM_VEC)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Lowest start at or above from of len vectors clear in the exclusive map,
    // and in the shareable map too when both is set; -1 when there is none
    function automatic int find_free_run(int from, int len, bit both);
        int  s;
        bit  clear;
        if (len > NUM_VEC)
            return -1;
        for (s = from; s + len <= NUM_VEC; s++) begin
            clear = 1'b1;
            for (int k = s; k < s + len; k++) begin
                if (excl_map[k] || (both && shr_map[k])) begin
                    clear = 1'b0;
                    break;
                end
            end
            if (clear)
                return s;
        end
        return -1;
    endfunction

    // Work out the result of one request and update the shadow maps
    function automatic ivra_rsp_t predict_grant(ivra_req_t req);
        ivra_rsp_t rsp;
        int        len;
        int        fv;
        int        start;
        int        at;
        rsp.granted_vector = '0;
        rsp.status         = IVRA_ST_OK;
        len = int'(req.run_length);
        fv  = int'(req.first_vector);
        if (req.mode == IVRA_MODE_FREE) begin
            if (len == 0) begin
                rsp.status = IVRA_ST_ZERO_LEN;
            end else begin
                for (int k = fv; k < fv + len && k < NUM_VEC; k++) begin
                    if (req.want_shared)
                        shr_map[k] = 1'b0;
                    else
                        excl_map[k] = 1'b0;
                end
            end
        end else if (req.priority_level < base_level_q) begin
            rsp.status = IVRA_ST_LOW_LVL;
        end else if (len == 0) begin
            rsp.status = IVRA_ST_ZERO_LEN;
        end else begin
            start = IVRA_SCAN_BASE
                  + ((int'(req.priority_level) - int'(base_level_q)) << IVRA_BLOCK_SHIFT);
            at = find_free_run(start, len, 1'b1);
            // shared requests fall back to runs free in the exclusive map only
            if (at < 0 && req.want_shared)
                at = find_free_run(start, len, 1'b0);
            if (at < 0) begin
                rsp.status = IVRA_ST_NO_ROOM;
            end else begin
                for (int k = at; k < at + len; k++) begin
                    if (req.want_shared)
                        shr_map[k] = 1'b1;
                    else
                        excl_map[k] = 1'b1;
                end
                rsp.granted_vector = 8'(at);
            end
        end
        return rsp;
    endfunction

    function automatic ivra_req_t make_req(logic mode, int len, int lvl, bit shr, int fv);
        ivra_req_t req;
        req.mode           = mode;
        req.run_length     = 9'(len);
        req.priority_level = 4'(lvl);
        req.want_shared    = shr;
        req.first_vector   = 8'(fv);
        return req;
    endfunction

    // Mostly allocations and frees of held runs, with some raw noise
    function automatic ivra_req_t random_req();
        ivra_req_t req;
        held_run_t run;
        int        pick;
        int        idx;
        int        len;
        int        lvl;
        pick = $urandom_range(99);
        if (pick < 10) begin
            req.mode           = 1'($urandom_range(1));
            req.run_length     = 9'($urandom_range(511));
            req.priority_level = 4'($urandom_range(15));
            req.want_shared    = 1'($urandom_range(1));
            req.first_vector   = 8'($urandom_range(255));
        end else if (pick < 45 && held_runs.size() != 0) begin
            idx = $urandom_range(held_runs.size() - 1);
            run = held_runs[idx];
            // now and then keep the run listed so it is freed twice
            if ($urandom_range(7) != 0)
                held_runs.delete(idx);
            req = make_req(IVRA_MODE_FREE, run.run_len, $urandom_range(15), run.in_shared,
                           run.first_vec);
        end else begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(8, 1);
            else if (pick < 95)
                len = $urandom_range(64, 9);
            else
                len = $urandom_range(256, 65);
            if ($urandom_range(9) == 0)
                lvl = $urandom_range(15);
            else
                lvl = $urandom_range(15, int'(base_level_q));
            req = make_req(IVRA_MODE_ALLOC, len, lvl, 1'($urandom_range(1)),
                           $urandom_range(255));
        end
        return req;
    endfunction

    // Drive one request word and hold it until it is taken
    task automatic send_req(input ivra_req_t req);
        ivra_rsp_t want;
        held_run_t run;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        want = predict_grant(req);
        if (req.mode == IVRA_MODE_ALLOC && want.status == IVRA_ST_OK) begin
            run.first_vec = want.granted_vector;
            run.run_len   = req.run_length;
            run.in_shared = req.want_shared;
            held_runs.push_back(run);
        end
        expected_grants.push_back(want);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_base_level(input logic [3:0] level);
        wait_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        base_level_q  = level;
    endtask

    task automatic report_mismatch(input string what, input ivra_rsp_t want,
                                   input ivra_rsp_t got);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("mismatch (%s): expected vector %0d status %0d, got vector %0d status %0d",
                     what, want.granted_vector, want.status, got.granted_vector, got.status);
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        ivra_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                want = '0;
                report_mismatch("no result expected", want, m_data);
            end else begin
                want = expected_grants.pop_front();
                if (m_data.granted_vector !== want.granted_vector)
                    report_mismatch("granted_vector", want, m_data);
                else if (m_data.status !== want.status)
                    report_mismatch("status", want, m_data);
            end
        end
    end

    // Extremes of the fields and every special case, from a known map state
    task automatic test_special_cases();
        send_req(make_req(IVRA_MODE_ALLOC,   4,  1, 1'b0,   0)); // level below base
        send_req(make_req(IVRA_MODE_ALLOC,   0,  0, 1'b0,   0)); // level checked first
        send_req(make_req(IVRA_MODE_ALLOC,   0,  2, 1'b1,   0)); // zero length
        send_req(make_req(IVRA_MODE_FREE,    0,  0, 1'b0,  17)); // zero length free
        send_req(make_req(IVRA_MODE_ALLOC,   1,  2, 1'b0, 255));
        send_req(make_req(IVRA_MODE_ALLOC,   1,  2, 1'b1,   0));
        send_req(make_req(IVRA_MODE_ALLOC,  16, 15, 1'b0,   0)); // top block
        send_req(make_req(IVRA_MODE_ALLOC,   1, 15, 1'b0,   0)); // nothing left above
        send_req(make_req(IVRA_MODE_ALLOC, 257,  2, 1'b0,   0)); // longer than the map
        send_req(make_req(IVRA_MODE_ALLOC, 511,  2, 1'b1,   0));
        send_req(make_req(IVRA_MODE_ALLOC, 206,  2, 1'b1,   0)); // fill the shared map
        send_req(make_req(IVRA_MODE_ALLOC,   1,  2, 1'b0,   0)); // no room
        send_req(make_req(IVRA_MODE_ALLOC,   8,  2, 1'b1,   0)); // shared fallback
        send_req(make_req(IVRA_MODE_FREE,  256,  0, 1'b0, 240)); // free past the top
        send_req(make_req(IVRA_MODE_FREE,  511, 15, 1'b1,   0));
        send_req(make_req(IVRA_MODE_FREE,    1,  0, 1'b0, 255));
        send_req(make_req(IVRA_MODE_FREE,  256,  3, 1'b0,   0));
        send_req(make_req(IVRA_MODE_ALLOC,   1, 15, 1'b0,   0));
        set_base_level(4'd0);
        send_req(make_req(IVRA_MODE_ALLOC,   1, 15, 1'b0,   0)); // start past the top
        send_req(make_req(IVRA_MODE_ALLOC, 256,  0, 1'b1,   0));
        send_req(make_req(IVRA_MODE_ALLOC, 208,  0, 1'b0,   0));
        set_base_level(4'd15);
        send_req(make_req(IVRA_MODE_ALLOC,   2, 14, 1'b0,   0));
        send_req(make_req(IVRA_MODE_ALLOC,   2, 15, 1'b1,   0));
        send_req(make_req(IVRA_MODE_FREE,  256,  0, 1'b0,   0));
        send_req(make_req(IVRA_MODE_FREE,  256,  0, 1'b1,   0));
        held_runs.delete();
    endtask

    // Random allocate and free traffic at one level setting and idling mix
    task automatic test_traffic(input int send_idle, input int recv_stall,
                                input logic [3:0] level);
        set_base_level(level);
        send_idle_pct = send_idle;
        stall_pct     = recv_stall;
        repeat (PHASE_ITEMS)
            send_req(random_req());
    endtask

    // Bound the run
    initial begin : watchdog
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL interrupt_vector_run_allocator_top");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_special_cases();
        test_traffic(0, 0, 4'd0);
        test_traffic(55, 0, 4'd15);
        test_traffic(0, 55, 4'd7);
        test_traffic(25, 25, IVRA_BASE_LEVEL_RESET);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_grants.size() == 0)
            $display("PASS interrupt_vector_run_allocator_top");
        else
            $display("FAIL interrupt_vector_run_allocator_top");
        $finish;
    end

endmodule
